### rtl/tpdc_pkg.sv
package tpdc_pkg;

  localparam int ADC_BITS   = 12;
  localparam int PWM_PERIOD = 1000;
  localparam int DUTY_W     = 10;
  localparam int DUTY_MAX   = (PWM_PERIOD < 1023) ? PWM_PERIOD : 1023;

  localparam int ADC_FULL   = 4095;
  localparam int R_PULLUP   = 10000;
  localparam int R_SPLIT_LO = 1918;
  localparam int R_SPLIT_HI = 5932;

  // Resistance at or below a split point is the same as the code being at or above a threshold.
  localparam int SEG1_MIN_CODE =
    (R_PULLUP * ADC_FULL + R_PULLUP + R_SPLIT_LO - 1) / (R_PULLUP + R_SPLIT_LO);
  localparam int SEG2_MIN_CODE =
    (R_PULLUP * ADC_FULL + R_PULLUP + R_SPLIT_HI - 1) / (R_PULLUP + R_SPLIT_HI);

  // Temperature is floor((code * K1 - (4095 - code) * K2) / (250 * code)) in Q8.8.
  localparam int SEG1_K1 = 64 * 116240 + 125;
  localparam int SEG1_K2 = 64000 * 275;
  localparam int SEG2_K1 = 64 * 78917 + 125;
  localparam int SEG2_K2 = 64000 * 76;
  localparam int SEG3_K1 = 64 * 47710 + 125;
  localparam int SEG3_K2 = 64000 * 22;

  localparam int TEMP_MAX     = 32767;
  localparam int TEMP_MIN_MAG = 32768;

  localparam int MUL_AW = ((ADC_BITS > 16) ? ADC_BITS : 16) + 1;
  localparam int MUL_BW = 26;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = ADC_BITS + 8;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int UPC_W  = 4;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_IDLE     = 4'd0;
  localparam upc_t UA_DISPATCH = 4'd1;
  localparam upc_t UA_SAMPLE   = 4'd2;
  localparam upc_t UA_MUL_POS  = 4'd3;
  localparam upc_t UA_MUL_NEG  = 4'd4;
  localparam upc_t UA_SUB      = 4'd5;
  localparam upc_t UA_DIV_INIT = 4'd6;
  localparam upc_t UA_DIV_STEP = 4'd7;
  localparam upc_t UA_TEMP     = 4'd8;
  localparam upc_t UA_ERR      = 4'd9;
  localparam upc_t UA_SLOPE    = 4'd10;
  localparam upc_t UA_TEMP_MIN = 4'd11;
  localparam upc_t UA_TARGET   = 4'd12;
  localparam upc_t UA_TICK     = 4'd13;
  localparam upc_t UA_EMIT     = 4'd14;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TARGET = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_DUTY_LOW   = 2'd0,
    REG_DUTY_HIGH  = 2'd1,
    REG_SLOPE_GAIN = 2'd2,
    REG_STEP_SHIFT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEG_HOT,
    SEG_MID,
    SEG_COLD
  } seg_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_SEG,
    UOP_MUL_POS,
    UOP_MUL_NEG,
    UOP_SUB,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_TEMP,
    UOP_TEMP_MIN,
    UOP_ERR_SLOPE,
    UOP_SLOPE,
    UOP_SETPT,
    UOP_TICK,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_ACCEPT,
    JMP_ACTION,
    JMP_ZERO,
    JMP_DIV,
    JMP_OUT
  } jmp_e;

  typedef struct packed {
    uop_e uop;
    jmp_e jmp;
    upc_t target;
  } ctrl_t;

  typedef struct packed {
    action_e             action;
    logic [ADC_BITS-1:0] adc_sample;
    logic [7:0]          target_degrees;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic signed [7:0]  temp_whole;
    logic signed [15:0] temp_fixed;
  } out_item_t;

  function automatic ctrl_t tpdc_ucode(input upc_t upc);
    ctrl_t w;
    w = '{uop: UOP_NOP, jmp: JMP_GOTO, target: UA_IDLE};
    case (upc)
      UA_IDLE:     w = '{uop: UOP_NOP,       jmp: JMP_ACCEPT, target: UA_DISPATCH};
      UA_DISPATCH: w = '{uop: UOP_NOP,       jmp: JMP_ACTION, target: UA_EMIT};
      UA_SAMPLE:   w = '{uop: UOP_SEG,       jmp: JMP_ZERO,   target: UA_TEMP_MIN};
      UA_MUL_POS:  w = '{uop: UOP_MUL_POS,   jmp: JMP_NEXT,   target: UA_IDLE};
      UA_MUL_NEG:  w = '{uop: UOP_MUL_NEG,   jmp: JMP_NEXT,   target: UA_IDLE};
      UA_SUB:      w = '{uop: UOP_SUB,       jmp: JMP_NEXT,   target: UA_IDLE};
      UA_DIV_INIT: w = '{uop: UOP_DIV_INIT,  jmp: JMP_NEXT,   target: UA_IDLE};
      UA_DIV_STEP: w = '{uop: UOP_DIV_STEP,  jmp: JMP_DIV,    target: UA_DIV_STEP};
      UA_TEMP:     w = '{uop: UOP_TEMP,      jmp: JMP_NEXT,   target: UA_IDLE};
      UA_ERR:      w = '{uop: UOP_ERR_SLOPE, jmp: JMP_NEXT,   target: UA_IDLE};
      UA_SLOPE:    w = '{uop: UOP_SLOPE,     jmp: JMP_GOTO,   target: UA_EMIT};
      UA_TEMP_MIN: w = '{uop: UOP_TEMP_MIN,  jmp: JMP_GOTO,   target: UA_ERR};
      UA_TARGET:   w = '{uop: UOP_SETPT,     jmp: JMP_GOTO,   target: UA_EMIT};
      UA_TICK:     w = '{uop: UOP_TICK,      jmp: JMP_NEXT,   target: UA_IDLE};
      UA_EMIT:     w = '{uop: UOP_EMIT,      jmp: JMP_OUT,    target: UA_IDLE};
      default:     w = '{uop: UOP_NOP,       jmp: JMP_GOTO,   target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/thermistor_pd_duty_controller.sv
// Channel | Direction | Handshake                | Beat
// in      | input     | in_valid_i / in_stall_o  | in_item_i: action, ADC code, setpoint
// out     | output    | out_valid_o / out_stall_i| out_item_o: duty, temperature
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample beat keeps the input closed from acceptance until the next beat can be
// taken; on the way it runs the one-bit-per-cycle divider that forms the temperature.
// A sample with code zero, a target beat or a tick beat skips the divider.
// Reset returns the sequencer to idle, loads the register reset values and empties
// the output register. A stalled result waits in the output register; only the
// final step of the next item waits for it.
module thermistor_pd_duty_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpdc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpdc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [9:0]          cfg_data_i
);
  import tpdc_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t ctrl;

  in_item_t item_q;
  logic [DUTY_W-1:0] duty_low_q, duty_high_q, duty_q;
  logic [7:0] gain_q;
  logic [2:0] shift_q;
  logic signed [15:0] temp_q, prev_q;
  logic signed [16:0] err_q;
  logic signed [23:0] slope_q;
  logic [7:0] setpt_q;

  seg_e seg_q, seg_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic signed [MUL_AW-1:0] code_ext, code_rest, mul_a;
  logic signed [MUL_BW-1:0] k1, k2, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [NUM_W-1:0] acc_q;
  logic [NUM_W-1:0] dvd_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0] rem_shift;
  logic qbit;
  logic neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W:0] qmag;
  logic signed [15:0] temp_div;

  logic signed [16:0] diff;
  logic [17:0] err_wide;
  logic signed [16:0] err_d;
  logic signed [23:0] slope_d;

  logic signed [24:0] sum, shifted;
  logic signed [17:0] step, duty_ext, duty_new;
  logic move_ok;
  logic [DUTY_W-1:0] duty_d;
  logic [7:0] whole;

  out_item_t out_q;
  logic out_valid_q;
  logic accept, out_free;

  assign ctrl        = tpdc_ucode(upc_q);
  assign in_stall_o  = (upc_q != UA_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    upc_d = upc_q + 1'b1;
    case (ctrl.jmp)
      JMP_NEXT:   upc_d = upc_q + 1'b1;
      JMP_GOTO:   upc_d = ctrl.target;
      JMP_ACCEPT: upc_d = in_valid_i ? ctrl.target : upc_q;
      JMP_ACTION: begin
        case (item_q.action)
          ACT_SAMPLE: upc_d = UA_SAMPLE;
          ACT_TARGET: upc_d = UA_TARGET;
          ACT_TICK:   upc_d = UA_TICK;
          default:    upc_d = ctrl.target;
        endcase
      end
      JMP_ZERO:   upc_d = (item_q.adc_sample == '0) ? ctrl.target : upc_q + 1'b1;
      JMP_DIV:    upc_d = (cnt_q != CNT_W'(1)) ? ctrl.target : upc_q + 1'b1;
      JMP_OUT:    upc_d = out_free ? ctrl.target : upc_q;
      default:    upc_d = UA_IDLE;
    endcase
  end

  assign code_ext  = MUL_AW'(item_q.adc_sample);
  assign code_rest = MUL_AW'(ADC_FULL) - code_ext;

  always_comb begin
    if (code_ext >= MUL_AW'(SEG1_MIN_CODE)) begin
      seg_d = SEG_HOT;
    end else if (code_ext >= MUL_AW'(SEG2_MIN_CODE)) begin
      seg_d = SEG_MID;
    end else begin
      seg_d = SEG_COLD;
    end
  end

  assign den_d = {item_q.adc_sample, 8'b0} - DEN_W'({item_q.adc_sample, 2'b0})
               - DEN_W'({item_q.adc_sample, 1'b0});

  always_comb begin
    case (seg_q)
      SEG_HOT: begin
        k1 = MUL_BW'(SEG1_K1);
        k2 = MUL_BW'(SEG1_K2);
      end
      SEG_MID: begin
        k1 = MUL_BW'(SEG2_K1);
        k2 = MUL_BW'(SEG2_K2);
      end
      default: begin
        k1 = MUL_BW'(SEG3_K1);
        k2 = MUL_BW'(SEG3_K2);
      end
    endcase
  end

  assign diff = 17'(temp_q) - 17'(prev_q);

  always_comb begin
    case (ctrl.uop)
      UOP_MUL_POS: begin
        mul_a = code_ext;
        mul_b = k1;
      end
      UOP_MUL_NEG: begin
        mul_a = code_rest;
        mul_b = k2;
      end
      UOP_ERR_SLOPE: begin
        mul_a = MUL_AW'(diff);
        mul_b = MUL_BW'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign rem_shift = {rem_q, dvd_q[NUM_W-1]};
  assign qbit      = (rem_shift >= {1'b0, den_q});
  always_comb begin
    if (qbit) begin
      rem_d = DEN_W'(rem_shift - {1'b0, den_q});
    end else begin
      rem_d = rem_shift[DEN_W-1:0];
    end
  end

  // Floor of a negative quotient is one further down when the division leaves a remainder.
  assign qmag = {1'b0, dvd_q} + (NUM_W+1)'(neg_q && (rem_q != '0));
  always_comb begin
    if (neg_q) begin
      temp_div = (qmag > (NUM_W+1)'(TEMP_MIN_MAG)) ? 16'sh8000 : 16'(16'd0 - qmag[15:0]);
    end else begin
      temp_div = (qmag > (NUM_W+1)'(TEMP_MAX)) ? 16'sh7FFF : qmag[15:0];
    end
  end

  assign err_wide = 18'(temp_q) - 18'({setpt_q, 8'b0});
  always_comb begin
    if (err_wide[17] != err_wide[16]) begin
      err_d = err_wide[17] ? 17'sh10000 : 17'sh0FFFF;
    end else begin
      err_d = err_wide[16:0];
    end
  end

  always_comb begin
    if ((&prod_q[PROD_W-1:23]) || !(|prod_q[PROD_W-1:23])) begin
      slope_d = prod_q[23:0];
    end else begin
      slope_d = prod_q[PROD_W-1] ? 24'sh800000 : 24'sh7FFFFF;
    end
  end

  assign sum      = 25'(err_q) + 25'(slope_q);
  assign shifted  = sum >>> (5'd8 + 5'(shift_q));
  assign step     = 18'(shifted);
  assign duty_ext = 18'(duty_q);
  assign duty_new = duty_ext + step;
  assign move_ok  = ((duty_q > duty_low_q) && (duty_q < duty_high_q))
                 || ((duty_q <= duty_low_q) && !sum[24] && (sum != '0))
                 || ((duty_q >= duty_high_q) && sum[24]);

  always_comb begin
    if (duty_new[17]) begin
      duty_d = '0;
    end else if (duty_new > 18'(DUTY_MAX)) begin
      duty_d = DUTY_W'(DUTY_MAX);
    end else begin
      duty_d = duty_new[DUTY_W-1:0];
    end
  end

  assign whole = 8'(temp_q >>> 8) + 8'(temp_q[15] && (temp_q[7:0] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UA_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      duty_low_q  <= DUTY_W'(50);
      duty_high_q <= DUTY_W'(950);
      gain_q      <= 8'd9;
      shift_q     <= 3'd1;
      temp_q      <= '0;
      prev_q      <= '0;
      err_q       <= '0;
      slope_q     <= '0;
      setpt_q     <= '0;
      duty_q      <= DUTY_W'(100);
    end else begin
      upc_q <= upc_d;
      if ((ctrl.uop == UOP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_DUTY_LOW:   duty_low_q  <= cfg_data_i;
          REG_DUTY_HIGH:  duty_high_q <= cfg_data_i;
          REG_SLOPE_GAIN: gain_q      <= cfg_data_i[7:0];
          REG_STEP_SHIFT: shift_q     <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      case (ctrl.uop)
        UOP_DIV_INIT: cnt_q <= CNT_W'(NUM_W);
        UOP_DIV_STEP: cnt_q <= cnt_q - 1'b1;
        UOP_TEMP:     temp_q <= temp_div;
        UOP_TEMP_MIN: temp_q <= 16'sh8000;
        UOP_ERR_SLOPE: err_q <= err_d;
        UOP_SLOPE: begin
          slope_q <= slope_d;
          prev_q  <= temp_q;
        end
        UOP_SETPT: setpt_q <= item_q.target_degrees;
        UOP_TICK: begin
          if (move_ok) begin
            duty_q <= duty_d;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    case (ctrl.uop)
      UOP_SEG: begin
        seg_q <= seg_d;
        den_q <= den_d;
      end
      UOP_MUL_POS: prod_q <= prod_d;
      UOP_MUL_NEG: begin
        prod_q <= prod_d;
        acc_q  <= NUM_W'(prod_q);
      end
      UOP_SUB: acc_q <= acc_q - NUM_W'(prod_q);
      UOP_DIV_INIT: begin
        neg_q <= acc_q[NUM_W-1];
        dvd_q <= acc_q[NUM_W-1] ? (~acc_q) + NUM_W'(1) : acc_q;
        rem_q <= '0;
      end
      UOP_DIV_STEP: begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[NUM_W-2:0], qbit};
      end
      UOP_ERR_SLOPE: prod_q <= prod_d;
      UOP_EMIT: begin
        if (out_free) begin
          out_q.duty       <= duty_q;
          out_q.temp_whole <= whole;
          out_q.temp_fixed <= temp_q;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/tpdc_checker.sv
module tpdc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tpdc_pkg::out_item_t out_item_o
);
  import tpdc_pkg::*;

  // The engine works on one item at a time, so a taken beat closes the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item was in flight");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.duty <= DUTY_W'(DUTY_MAX)))
    else $error("duty outside the period range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("stalled output beat changed");

endmodule

bind thermistor_pd_duty_controller tpdc_checker u_tpdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### test/tb_thermistor_pd_duty_controller.sv
module tb_thermistor_pd_duty_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import tpdc_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD   = 1500;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 215;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  thermistor_pd_duty_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Controller state and registers as the block holds them.
  logic signed [15:0] temp_q88 = '0;
  logic signed [15:0] prev_q88 = '0;
  logic signed [16:0] err_q88 = '0;
  logic signed [23:0] slope_q88 = '0;
  logic [7:0]         setpoint = '0;
  logic [9:0]         duty_now = 10'd100;
  logic [9:0]         duty_low = 10'd50;
  logic [9:0]         duty_high = 10'd950;
  logic [7:0]         slope_gain = 8'd9;
  logic [2:0]         step_shift = 3'd1;

  in_item_t  pending_items[$];
  out_item_t expected_readings[$];
  out_item_t want;
  int        fail_count = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        hold_left = 0;
  int        hold_idx = 0;
  int        stall_mode = 0;
  int        mode_left = 0;
  int        last_code = 2048;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [15:0] code_to_q88(logic [ADC_BITS-1:0] code);
    longint c, a, b, num, den, q;
    c = longint'(code);
    if (c == 0) return 16'sh8000;
    if (10000 * (4095 - c) <= 1918 * c) begin
      a = 275;
      b = 116240;
    end else if (10000 * (4095 - c) <= 5932 * c) begin
      a = 76;
      b = 78917;
    end else begin
      a = 22;
      b = 47710;
    end
    num = -256000 * a * (4095 - c) + 256 * b * c;
    den = 1000 * c;
    num = 2 * num + den;
    den = 2 * den;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    return 16'(sat(q, -32768, 32767));
  endfunction

  function automatic out_item_t predict_reading(in_item_t it);
    longint    sum, d;
    out_item_t r;
    case (it.action)
      ACT_SAMPLE: begin
        temp_q88  = code_to_q88(it.adc_sample);
        err_q88   = 17'(sat(longint'(temp_q88) - 256 * longint'(setpoint), -65536, 65535));
        slope_q88 = 24'(sat(longint'(slope_gain) * (longint'(temp_q88) - longint'(prev_q88)),
                            -8388608, 8388607));
        prev_q88  = temp_q88;
      end
      ACT_TARGET: setpoint = it.target_degrees;
      ACT_TICK: begin
        sum = longint'(err_q88) + longint'(slope_q88);
        d   = longint'(duty_now);
        if ((d > longint'(duty_low) && d < longint'(duty_high)) ||
            (d <= longint'(duty_low) && sum > 0) ||
            (d >= longint'(duty_high) && sum < 0)) begin
          duty_now = 10'(sat(d + (sum >>> (8 + step_shift)), 0, DUTY_MAX));
        end
      end
      default: ;
    endcase
    r.duty       = duty_now;
    r.temp_whole = 8'(longint'(temp_q88) / 256);
    r.temp_fixed = temp_q88;
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] act, int code, int tgt);
    in_item_t it;
    it.action         = action_e'(act);
    it.adc_sample     = code[ADC_BITS-1:0];
    it.target_degrees = tgt[7:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    int sel, code, tgt;
    sel  = $urandom_range(0, 99);
    code = $urandom_range(0, 4095);
    tgt  = $urandom_range(0, 255);
    if (sel < 40) begin
      case ($urandom_range(0, 9))
        0:       code = $urandom_range(0, 4095);
        1:       code = $urandom_range(0, 8);
        2:       code = $urandom_range(4080, 4095);
        3:       code = $urandom_range(3433, 3439);
        4:       code = $urandom_range(2568, 2574);
        default: code = int'(sat(last_code + int'($urandom_range(0, 40)) - 20, 1, 4095));
      endcase
      last_code = (code == 0) ? last_code : code;
      return make_item(ACT_SAMPLE, code, tgt);
    end else if (sel < 85) begin
      return make_item(ACT_TICK, code, tgt);
    end else if (sel < 95) begin
      if ($urandom_range(0, 1) == 0) tgt = $urandom_range(0, 60);
      return make_item(ACT_TARGET, code, tgt);
    end
    return make_item(2'd3, code, tgt);
  endfunction

  task automatic write_reg(cfg_reg_e idx, int val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[9:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DUTY_LOW:   duty_low   = val[9:0];
      REG_DUTY_HIGH:  duty_high  = val[9:0];
      REG_SLOPE_GAIN: slope_gain = val[7:0];
      default:        step_shift = val[2:0];
    endcase
  endtask

  task automatic wait_idle(int settle);
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) expected_readings.push_back(predict_reading(in_item));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changing stall patterns plus two long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((hold_idx == 0 && results_seen >= 300) ||
                 (hold_idx == 1 && results_seen >= 1200)) begin
      hold_idx++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(5, 120);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= ($urandom_range(0, 9) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_readings.size() == 0) begin
        $error("result with nothing expected: duty %0d temp_fixed %0d",
               out_item.duty, out_item.temp_fixed);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_item.duty !== want.duty) begin
          $error("duty: expected %0d, actual %0d", want.duty, out_item.duty);
          fail_count++;
        end
        if (out_item.temp_whole !== want.temp_whole) begin
          $error("temp_whole: expected %0d, actual %0d", want.temp_whole, out_item.temp_whole);
          fail_count++;
        end
        if (out_item.temp_fixed !== want.temp_fixed) begin
          $error("temp_fixed: expected %0d, actual %0d", want.temp_fixed, out_item.temp_fixed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int lo, hi, g, s;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the registers are in force here.
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(2'd3, 4095, 255));
    pending_items.push_back(make_item(ACT_TARGET, 0, 255));
    pending_items.push_back(make_item(ACT_SAMPLE, 4095, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 4095, 255));
    pending_items.push_back(make_item(ACT_TARGET, 4095, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 1, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 3436, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 3435, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 2571, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 2570, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 4095, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    pending_items.push_back(make_item(2'd3, 0, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 2048, 170));
    pending_items.push_back(make_item(ACT_TARGET, 1365, 128));
    pending_items.push_back(make_item(ACT_TICK, 2730, 85));
    pending_items.push_back(make_item(ACT_SAMPLE, 0, 0));
    pending_items.push_back(make_item(ACT_TICK, 0, 0));
    wait_idle(20);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin lo = 0;    hi = 1000; g = 0;   s = 0; end
        1: begin lo = 1000; hi = 0;    g = 255; s = 7; end
        2: begin lo = 50;   hi = 950;  g = 9;   s = 1; end
        3: begin lo = 300;  hi = 700;  g = 255; s = 0; end
        4: begin lo = 0;    hi = 1000; g = 128; s = 3; end
        5: begin
          lo = $urandom_range(0, 400);
          hi = $urandom_range(600, 1000);
          g  = $urandom_range(0, 255);
          s  = $urandom_range(0, 7);
        end
        default: begin
          lo = $urandom_range(0, 1000);
          hi = $urandom_range(0, 1000);
          g  = $urandom_range(0, 255);
          s  = $urandom_range(0, 7);
        end
      endcase
      write_reg(REG_DUTY_LOW, lo);
      write_reg(REG_DUTY_HIGH, hi);
      write_reg(REG_SLOPE_GAIN, g);
      write_reg(REG_STEP_SHIFT, s);
      repeat (PHASE_ITEMS) pending_items.push_back(random_item());
      wait_idle(20);
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
